>>> sv/cft_pkg.sv
// Shared types and constants for the Carmichael/Fermat test block.
package cft_pkg;

	localparam int unsigned NUMBER_BITS_DEF = 31;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_STRIP, ST_CHK2, ST_SQ, ST_TEST, ST_WMP,
		ST_DMP2, ST_WMP2, ST_WTL, ST_LAST, ST_WTM
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_SHIFT, CMD_P_INIT, CMD_SQUARE, CMD_DIV_MP,
		CMD_FIRST, CMD_NEXT_POW, CMD_DIV_TL, CMD_P_NEXT, CMD_DIV_TM
	} cmd_t;

	typedef struct packed {
		logic le_two;
		logic m_even;
		logic k_nonzero;
		logic pow2_ok;
		logic sq_gt_m;
		logic m_gt1;
		logic div_done;
		logic rem_zero;
	} status_t;

endpackage

>>> sv/cft_div.sv
// Restoring divider, one quotient bit per cycle.
module cft_div #(
	parameter int unsigned W = cft_pkg::NUMBER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W:0]   rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic         run_q;
	logic         done_q;
	logic [W:0]   rem_sh;
	logic         fits;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[W-1:0];
endmodule

>>> sv/cft_datapath.sv
// Datapath: candidate, cofactor, trial prime, lambda and the shared divider.
module cft_datapath #(
	parameter int unsigned W = cft_pkg::NUMBER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cft_pkg::cmd_t     cmd,
	input  logic [W-1:0]      candidate,
	output cft_pkg::status_t  status
);
	localparam int unsigned KW = $clog2(W + 1);

	logic [W-1:0]   tgt_q, m_q, p_q, lam_q;
	logic [2*W-1:0] sq_q;
	logic [KW-1:0]  k_q;
	logic           go;
	logic [W-1:0]   dvd, dvs, quo, rem;
	logic           done;
	logic [2*W-1:0] lam_prod;
	logic [W-1:0]   mask2;

	assign lam_prod = lam_q * p_q;
	// lambda(2^k) - 1 as a mask
	assign mask2 = (k_q <= KW'(2)) ? ((W'(1) << (k_q - 1'b1)) - 1'b1)
	                               : ((W'(1) << (k_q - KW'(2))) - 1'b1);

	always_comb begin
		go  = 1'b0;
		dvd = m_q;
		dvs = p_q;
		unique case (cmd)
			cft_pkg::CMD_DIV_MP: go = 1'b1;
			cft_pkg::CMD_DIV_TL: begin
				go  = 1'b1;
				dvd = tgt_q;
				dvs = lam_q;
			end
			cft_pkg::CMD_DIV_TM: begin
				go  = 1'b1;
				dvd = tgt_q;
				dvs = m_q - 1'b1;
			end
			default: go = 1'b0;
		endcase
	end

	cft_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .go(go), .dividend(dvd), .divisor(dvs),
		.done(done), .quo(quo), .rem(rem)
	);

	always_ff @(posedge clk) begin
		unique case (cmd)
			cft_pkg::CMD_LOAD: begin
				tgt_q <= candidate - 1'b1;
				m_q   <= candidate;
				k_q   <= '0;
			end
			cft_pkg::CMD_SHIFT: begin
				m_q <= m_q >> 1;
				k_q <= k_q + 1'b1;
			end
			cft_pkg::CMD_P_INIT:   p_q   <= W'(3);
			cft_pkg::CMD_SQUARE:   sq_q  <= p_q * p_q;
			cft_pkg::CMD_FIRST: begin
				m_q   <= quo;
				lam_q <= p_q - 1'b1;
			end
			cft_pkg::CMD_NEXT_POW: begin
				m_q   <= quo;
				lam_q <= lam_prod[W-1:0];
			end
			cft_pkg::CMD_P_NEXT:   p_q   <= p_q + W'(2);
			default: ;
		endcase
	end

	// only looked at straight after load, while m_q still holds the word
	assign status.le_two    = m_q <= W'(2);
	assign status.m_even    = ~m_q[0];
	assign status.k_nonzero = k_q != '0;
	assign status.pow2_ok   = (tgt_q & mask2) == '0;
	assign status.sq_gt_m   = sq_q > {{W{1'b0}}, m_q};
	assign status.m_gt1     = m_q > W'(1);
	assign status.div_done  = done;
	assign status.rem_zero  = rem == '0;
endmodule

>>> sv/cft_ctrl.sv
// Controller: sequences factoring by trial division and the lambda checks.
module cft_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cft_pkg::status_t status,
	output cft_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             fin,
	output logic             verdict
);
	cft_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cft_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = cft_pkg::CMD_NONE;
		fin     = 1'b0;
		verdict = 1'b1;
		unique case (state_q)
			cft_pkg::ST_IDLE: if (start) begin
				cmd     = cft_pkg::CMD_LOAD;
				state_d = cft_pkg::ST_INIT;
			end
			cft_pkg::ST_INIT: begin
				if (status.le_two) begin
					fin     = 1'b1;
					state_d = cft_pkg::ST_IDLE;
				end else state_d = cft_pkg::ST_STRIP;
			end
			cft_pkg::ST_STRIP: begin
				if (status.m_even) cmd = cft_pkg::CMD_SHIFT;
				else state_d = cft_pkg::ST_CHK2;
			end
			cft_pkg::ST_CHK2: begin
				if (status.k_nonzero && !status.pow2_ok) begin
					fin     = 1'b1;
					verdict = 1'b0;
					state_d = cft_pkg::ST_IDLE;
				end else begin
					cmd     = cft_pkg::CMD_P_INIT;
					state_d = cft_pkg::ST_SQ;
				end
			end
			cft_pkg::ST_SQ: begin
				cmd     = cft_pkg::CMD_SQUARE;
				state_d = cft_pkg::ST_TEST;
			end
			cft_pkg::ST_TEST: begin
				if (status.sq_gt_m) state_d = cft_pkg::ST_LAST;
				else begin
					cmd     = cft_pkg::CMD_DIV_MP;
					state_d = cft_pkg::ST_WMP;
				end
			end
			cft_pkg::ST_WMP: if (status.div_done) begin
				if (status.rem_zero) begin
					cmd     = cft_pkg::CMD_FIRST;
					state_d = cft_pkg::ST_DMP2;
				end else begin
					cmd     = cft_pkg::CMD_P_NEXT;
					state_d = cft_pkg::ST_SQ;
				end
			end
			cft_pkg::ST_DMP2: begin
				cmd     = cft_pkg::CMD_DIV_MP;
				state_d = cft_pkg::ST_WMP2;
			end
			cft_pkg::ST_WMP2: if (status.div_done) begin
				if (status.rem_zero) begin
					cmd     = cft_pkg::CMD_NEXT_POW;
					state_d = cft_pkg::ST_DMP2;
				end else begin
					cmd     = cft_pkg::CMD_DIV_TL;
					state_d = cft_pkg::ST_WTL;
				end
			end
			cft_pkg::ST_WTL: if (status.div_done) begin
				if (status.rem_zero) begin
					cmd     = cft_pkg::CMD_P_NEXT;
					state_d = cft_pkg::ST_SQ;
				end else begin
					fin     = 1'b1;
					verdict = 1'b0;
					state_d = cft_pkg::ST_IDLE;
				end
			end
			cft_pkg::ST_LAST: begin
				if (status.m_gt1) begin
					cmd     = cft_pkg::CMD_DIV_TM;
					state_d = cft_pkg::ST_WTM;
				end else begin
					fin     = 1'b1;
					state_d = cft_pkg::ST_IDLE;
				end
			end
			cft_pkg::ST_WTM: if (status.div_done) begin
				fin     = 1'b1;
				verdict = status.rem_zero;
				state_d = cft_pkg::ST_IDLE;
			end
			default: state_d = cft_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != cft_pkg::ST_IDLE;
endmodule

>>> sv/carmichael_fermat_test.sv
// Top level of the Carmichael/Fermat test block.
// Use: drive candidate and pulse start while busy is low; the word is taken
// at that edge. busy stays high until the answer is known.
// The answer appears on passes_all_bases, which holds it until the next answer,
// marked by done for exactly one cycle, in the cycle in which busy falls; the
// receiver cannot stall it, and a new start may be given while done is high.
// Method: n is factored by trial division and lambda(n) | n-1 is checked,
// which equals testing every coprime base. Candidates of 2 or less pass.
// Cost: the shared divider serves every division, one at a time, and each odd
// trial divisor up to sqrt(n) costs at least one division, so the time per
// item grows with sqrt(n); a new item is taken only once busy is low.
// Reset: arst_n clears the controller and any pending answer; no answer is
// produced for an item in flight.
module carmichael_fermat_test #(
	parameter int unsigned NUMBER_BITS = cft_pkg::NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMBER_BITS-1:0] candidate,
	output logic                   busy,
	output logic                   done,
	output logic                   passes_all_bases
);
	cft_pkg::cmd_t    cmd;
	cft_pkg::status_t status;
	logic             fin, verdict;
	logic             done_q, pass_q;

	cft_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.cmd(cmd), .busy(busy), .fin(fin), .verdict(verdict)
	);

	cft_datapath #(.W(NUMBER_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .candidate(candidate),
		.status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= fin;
	end

	always_ff @(posedge clk) begin
		if (fin) pass_q <= verdict;
	end

	assign done             = done_q;
	assign passes_all_bases = pass_q;
endmodule

>>> test/cft_checker.sv
// Checker for carmichael_fermat_test: predicts each answer and compares it with passes_all_bases when done is high.
module cft_checker #(
	parameter int unsigned NUMBER_BITS = cft_pkg::NUMBER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic [NUMBER_BITS-1:0] candidate,
	input  logic                   done,
	input  logic                   passes_all_bases,
	output int                     fail_count,
	output int                     pending
);

	bit answer_q[$];

	// lambda of a prime power p^k
	function automatic longint unsigned prime_power_lambda(longint unsigned p, int k);
		longint unsigned v;
		v = p - 1;
		if (p == 2) begin
			if (k <= 2)
				return longint'(1) << (k - 1);
			return longint'(1) << (k - 2);
		end
		for (int i = 1; i < k; i++)
			v = v * p;
		return v;
	endfunction

	// every coprime base satisfies Fermat exactly when lambda(n) divides n-1
	function automatic bit all_bases_pass(longint unsigned n);
		longint unsigned m, tgt, p;
		int k;
		m = n;
		if (n <= 2)
			return 1'b1;
		tgt = n - 1;
		k = 0;
		while (m[0] == 1'b0) begin
			m = m >> 1;
			k++;
		end
		if (k > 0 && (tgt % prime_power_lambda(2, k)) != 0)
			return 1'b0;
		for (p = 3; p * p <= m; p += 2) begin
			if (m % p != 0)
				continue;
			k = 0;
			while (m % p == 0) begin
				m = m / p;
				k++;
			end
			if ((tgt % prime_power_lambda(p, k)) != 0)
				return 1'b0;
		end
		if (m > 1 && (tgt % (m - 1)) != 0)
			return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
			answer_q.delete();
		end else begin
			if (start && !busy)
				answer_q.push_back(all_bases_pass(longint'(candidate)));
			if (done) begin
				if (answer_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected answer word %0b", passes_all_bases);
					fail_count <= fail_count + 1;
				end else begin
					want = answer_q.pop_front();
					if (passes_all_bases !== want) begin
						if (fail_count < 10)
							$display("passes_all_bases: expected %0b got %0b", want,
								passes_all_bases);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= answer_q.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Testbench top for carmichael_fermat_test: stimulus, timeout and verdict.
module tb_top;

	localparam int unsigned NB = cft_pkg::NUMBER_BITS_DEF;
	localparam longint CYCLE_LIMIT = 20_000_000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic [NB-1:0] candidate;
	logic          busy, done, passes_all_bases;
	int            fail_count, pending;
	longint        cycles = 0;

	carmichael_fermat_test #(.NUMBER_BITS(NB)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .candidate(candidate),
		.busy(busy), .done(done), .passes_all_bases(passes_all_bases)
	);

	cft_checker #(.NUMBER_BITS(NB)) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .candidate(candidate),
		.done(done), .passes_all_bases(passes_all_bases),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("carmichael_fermat_test verification failed");
			$finish;
		end
	end

	// holds start high until the word is taken
	task automatic send_word(input logic [NB-1:0] n);
		start     <= 1'b1;
		candidate <= n;
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// product of small primes, kept cheap to factor
	function automatic logic [NB-1:0] smooth_number();
		longint unsigned v, f;
		int primes[6] = '{2, 3, 5, 7, 11, 13};
		v = 1;
		for (int i = 0; i < 30; i++) begin
			f = 64'(primes[$urandom_range(0, 5)]);
			if (v * f < (longint'(1) << NB))
				v = v * f;
		end
		return NB'(v);
	endfunction

	function automatic logic [NB-1:0] random_candidate();
		int unsigned sel;
		logic [NB-1:0] known[8] = '{561, 1105, 1729, 2465, 2821, 6601, 8911, 65537};
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return NB'($urandom_range(0, 4095));
		else if (sel < 80)
			return NB'($urandom_range(0, (1 << 20) - 1));
		else if (sel < 90)
			return known[$urandom_range(0, 7)];
		return smooth_number();
	endfunction

	initial begin
		logic [NB-1:0] directed[$];
		int sent, burst;
		arst_n    = 1'b0;
		start     = 1'b0;
		candidate = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tiny values, Carmichael numbers, primes, composites, wide smooth words
		directed = '{0, 1, 2, 3, 4, 5, 9, 15, 561, 1105, 1729, 2465, 41041, 7919, 7917,
			31'h4000_0000, 31'h7FFF_FFFE, 31'd1162261467, 31'd1073741824 + 31'd2};
		foreach (directed[i]) begin
			send_word(directed[i]);
			if (i % 4 == 3)
				idle_cycles($urandom_range(1, 15));
		end
		drain();

		sent = 0;
		while (sent < 100) begin
			burst = $urandom_range(1, 8);
			for (int j = 0; j < burst && sent < 100; j++) begin
				send_word(random_candidate());
				sent++;
			end
			if (sent >= 50 && sent - burst < 50)
				drain();
			else
				idle_cycles($urandom_range(0, 20));
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("carmichael_fermat_test verification clean");
		else
			$display("carmichael_fermat_test verification failed");
		$finish;
	end

endmodule
